// File: rtl/scfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo control word and fault auto-reset: shared package
// Item, result, state and configuration types, register indexes, reset
// values and the control and status word bit positions.
// ----------------------------------------------------------------------------
package scfa_pkg;

  // Configuration register indexes.
  localparam logic [7:0] CfgIdxPeriod = 8'd0;
  localparam logic [7:0] CfgIdxRetry  = 8'd1;

  // Configuration reset values.
  localparam logic [15:0] DefaultPeriodCycles = 16'd100;
  localparam logic [7:0]  DefaultRetryLimit   = 8'd3;

  // Control word bit positions.
  localparam int unsigned CwSwitchOn   = 0;
  localparam int unsigned CwEnableVolt = 1;
  localparam int unsigned CwNotQstop   = 2;
  localparam int unsigned CwEnableOp   = 3;
  localparam int unsigned CwFaultReset = 7;
  localparam int unsigned CwHalt       = 8;

  // Status word bit positions.
  localparam int unsigned SwSwitchedOn = 1;
  localparam int unsigned SwFault      = 3;

  // Stream payload widths.
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  typedef struct packed {
    logic        link_operational;
    logic [15:0] status_word;
    logic        cmd_switch_on;
    logic        cmd_enable_voltage;
    logic        cmd_quick_stop;
    logic        cmd_enable_operation;
    logic        cmd_fault_reset;
    logic        cmd_halt;
  } item_t;

  typedef struct packed {
    logic [8:0]  control_word;
    logic        fault_out;
    logic [10:0] status_flags;
  } result_t;

  typedef struct packed {
    logic        prev_switch_on;
    logic        drive_fault_seen;
    logic [7:0]  retries_left;
    logic        reset_pulse_level;
    logic [15:0] period_counter;
  } state_t;

  typedef struct packed {
    logic [15:0] reset_period_cycles;
    logic [7:0]  reset_retry_limit;
  } cfg_t;

endpackage : scfa_pkg
`default_nettype wire

// File: rtl/scfa_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo control word and fault auto-reset: one servo period
// Decodes the status word, advances the auto-reset sequencer and builds the
// control word for one item, given the current state and configuration.
// ----------------------------------------------------------------------------
module scfa_step (
  input  wire scfa_pkg::item_t   item_i,
  input  wire scfa_pkg::state_t  state_i,
  input  wire scfa_pkg::cfg_t    cfg_i,
  output scfa_pkg::state_t       state_o,
  output scfa_pkg::result_t      result_o
);
  import scfa_pkg::*;

  always_comb begin
    state_t      st;
    logic [15:0] sw;
    logic        drv_on;
    logic        rise;
    logic [8:0]  cw;
    logic [10:0] flags;
    logic        fault;

    st          = state_i;
    sw          = item_i.status_word;
    drv_on      = 1'b0;
    flags       = '0;
    fault       = 1'b1;
    cw          = '0;

    // Read phase: only a live link updates the decoded state.
    if (item_i.link_operational) begin
      flags = {sw[12], sw[11], sw[10], sw[9], sw[7], sw[6], ~sw[5],
               sw[4], sw[2], sw[1], sw[0]};
      drv_on              = sw[SwSwitchedOn];
      st.drive_fault_seen = sw[SwFault];
      if (!st.drive_fault_seen) begin
        st.retries_left = '0;
      end
      if (st.retries_left != '0) begin
        if (st.period_counter < cfg_i.reset_period_cycles) begin
          st.period_counter = st.period_counter + 16'd1;
        end else begin
          st.period_counter    = '0;
          st.reset_pulse_level = ~st.reset_pulse_level;
          if (st.reset_pulse_level) begin
            st.retries_left = st.retries_left - 8'd1;
          end
        end
        fault = 1'b0;
      end else begin
        fault = st.drive_fault_seen;
      end
    end

    // Write phase: a switch-on rising edge during a fault starts auto-reset.
    rise              = item_i.cmd_switch_on & ~state_i.prev_switch_on;
    st.prev_switch_on = item_i.cmd_switch_on;
    if ((cfg_i.reset_retry_limit != '0) && (cfg_i.reset_period_cycles != '0) &&
        rise && st.drive_fault_seen) begin
      st.retries_left      = cfg_i.reset_retry_limit;
      st.reset_pulse_level = 1'b1;
      st.period_counter    = '0;
    end

    // Control word assembly.
    cw[CwEnableVolt] = item_i.cmd_enable_voltage;
    cw[CwNotQstop]   = ~item_i.cmd_quick_stop;
    cw[CwFaultReset] = item_i.cmd_fault_reset;
    cw[CwHalt]       = item_i.cmd_halt;
    if (st.retries_left != '0) begin
      cw[CwFaultReset] = item_i.cmd_fault_reset | st.reset_pulse_level;
    end else begin
      cw[CwSwitchOn] = item_i.cmd_switch_on;
      cw[CwEnableOp] = item_i.cmd_enable_operation & drv_on;
    end

    state_o               = st;
    result_o.control_word = cw;
    result_o.fault_out    = fault;
    result_o.status_flags = flags;
  end

endmodule : scfa_step
`default_nettype wire

// File: rtl/servo_controlword_fault_autoreset_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo control word builder with fault auto-reset
// Two-stage stream block: an input register, then the per-period logic
// feeding a result register. The sequencer state updates as each result
// is registered.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       tdata: item, tuser: link
//   m_axis    out        m_axis_tvalid/tready       tdata: result
//   cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// One item per clock sustained while the output does not stall; the result
// goes from the input register through the per-period logic to m_axis.
// The rate is set by the combinational state update in the second stage.
// Reset clears the sequencer state and loads the register defaults.
// A stalled output holds its result; input is still taken while the input
// register is empty or moves into the result register.
// ----------------------------------------------------------------------------
module servo_controlword_fault_autoreset_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Fields from bit 0: status_word[15:0], cmd_switch_on, cmd_enable_voltage,
  // cmd_quick_stop, cmd_enable_operation, cmd_fault_reset, cmd_halt, zeros.
  input  wire [scfa_pkg::InDataW-1:0]      s_axis_tdata,
  // Fields from bit 0: link_operational.
  input  wire                              s_axis_tuser,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: control_word[8:0], fault_out, status_flags[10:0], zeros.
  output logic [scfa_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [7:0]                        cfg_index_i,
  input  wire [15:0]                       cfg_data_i
);
  import scfa_pkg::*;

  item_t   in_q;
  logic    in_vld_q;
  result_t res_q;
  result_t res_d;
  logic    out_vld_q;
  state_t  state_q;
  state_t  state_d;
  cfg_t    cfg_q;
  logic    advance;
  logic    take;

  // Stage 2 moves when the result register is free or being drained.
  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;
  assign take          = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_period_cycles <= DefaultPeriodCycles;
      cfg_q.reset_retry_limit   <= DefaultRetryLimit;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxPeriod) begin
        cfg_q.reset_period_cycles <= cfg_data_i;
      end
      if (cfg_index_i == CfgIdxRetry) begin
        cfg_q.reset_retry_limit <= cfg_data_i[7:0];
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q.link_operational     <= s_axis_tuser;
      in_q.status_word          <= s_axis_tdata[15:0];
      in_q.cmd_switch_on        <= s_axis_tdata[16];
      in_q.cmd_enable_voltage   <= s_axis_tdata[17];
      in_q.cmd_quick_stop       <= s_axis_tdata[18];
      in_q.cmd_enable_operation <= s_axis_tdata[19];
      in_q.cmd_fault_reset      <= s_axis_tdata[20];
      in_q.cmd_halt             <= s_axis_tdata[21];
    end
  end

  // Per-period logic.
  scfa_step u_step (
    .item_i   (in_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Sequencer state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, res_q.status_flags, res_q.fault_out, res_q.control_word};

  // Retries are only ever pending while a drive fault is latched.
  a_retry_needs_fault : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.retries_left != '0) |-> state_q.drive_fault_seen)
    else $error("retries pending without a latched fault");

  // Input back-pressure only when both stages are full and the output stalls.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  // The sequencer state moves only when a result is registered.
  a_state_on_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("sequencer state changed without an item");

  // A registered result with its link down reports a fault and no flags.
  a_link_down_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_q.link_operational) |=>
      (res_q.fault_out && (res_q.status_flags == '0)))
    else $error("link-down result is not a fault");

endmodule : servo_controlword_fault_autoreset_top
`default_nettype wire

// File: tb/sv/servo_controlword_fault_autoreset_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo control word and fault auto-reset: stream testbench
// Drives servo periods into the block, with random idle bursts on the input
// and random stalls on the output. Each accepted period is run through a
// behavioral model of the status decode, the fault latch and the auto-reset
// sequencer, and every result is checked field by field in order. The run
// starts with a short directed table and goes on with random phases under
// several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module servo_controlword_fault_autoreset_top_tb;
  import scfa_pkg::*;

  // An index that maps to no register; writes to it must be ignored.
  localparam logic [7:0] CfgIdxUnused = 8'hA5;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned NumPhases = 10;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } dir_row_t;

  typedef struct {
    logic [15:0] period;
    logic [7:0]  retry;
    int          count;
    int          flip_div;
    int          noise_pct;
    bit          calm;
  } phase_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [7:0]          cfg_index_i = '0;
  logic [15:0]         cfg_data_i = '0;

  // Model copies of the sequencer state and the registers.
  state_t      drive_model;
  cfg_t        model_cfg;
  result_t     pending_results[$];

  // Directed-row tag that travels with the item currently on the input.
  bit          row_typed = 1'b0;
  result_t     row_res = '0;

  bit          calm = 1'b0;
  logic        fault_level = 1'b0;
  logic        on_level = 1'b0;
  int unsigned err_count = 0;
  int unsigned stall_cycles = 0;

  dir_row_t    dir_rows[$];
  phase_t      phases[NumPhases];

  servo_controlword_fault_autoreset_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // One servo period of the model: read phase, then write phase.
  function automatic result_t predict_period(input item_t it);
    result_t     r;
    logic [15:0] sw;
    logic        sw_on;
    logic        rise;
    r = '0;
    r.fault_out = 1'b1;
    sw_on = 1'b0;
    sw = it.status_word;
    if (it.link_operational) begin
      r.status_flags = {sw[12], sw[11], sw[10], sw[9], sw[7], sw[6], ~sw[5], sw[4],
                        sw[2], sw[1], sw[0]};
      sw_on = sw[SwSwitchedOn];
      drive_model.drive_fault_seen = sw[SwFault];
      if (!drive_model.drive_fault_seen) drive_model.retries_left = '0;
      if (drive_model.retries_left != 0) begin
        if (drive_model.period_counter < model_cfg.reset_period_cycles) begin
          drive_model.period_counter = drive_model.period_counter + 16'd1;
        end else begin
          drive_model.period_counter = '0;
          drive_model.reset_pulse_level = ~drive_model.reset_pulse_level;
          if (drive_model.reset_pulse_level) begin
            drive_model.retries_left = drive_model.retries_left - 8'd1;
          end
        end
        r.fault_out = 1'b0;
      end else begin
        r.fault_out = drive_model.drive_fault_seen;
      end
    end

    rise = it.cmd_switch_on && !drive_model.prev_switch_on;
    drive_model.prev_switch_on = it.cmd_switch_on;
    if (model_cfg.reset_retry_limit != 0 && model_cfg.reset_period_cycles != 0 &&
        rise && drive_model.drive_fault_seen) begin
      drive_model.retries_left = model_cfg.reset_retry_limit;
      drive_model.reset_pulse_level = 1'b1;
      drive_model.period_counter = '0;
    end

    r.control_word[CwEnableVolt] = it.cmd_enable_voltage;
    r.control_word[CwNotQstop]   = ~it.cmd_quick_stop;
    r.control_word[CwFaultReset] = it.cmd_fault_reset;
    r.control_word[CwHalt]       = it.cmd_halt;
    if (drive_model.retries_left != 0) begin
      if (drive_model.reset_pulse_level) r.control_word[CwFaultReset] = 1'b1;
    end else begin
      r.control_word[CwSwitchOn] = it.cmd_switch_on;
      r.control_word[CwEnableOp] = it.cmd_enable_operation && sw_on;
    end
    return r;
  endfunction

  // Random period: the fault bit and switch-on are held and flipped now and
  // then, so that auto-reset sequences get started and run their course.
  function automatic item_t next_period_item(input phase_t ph);
    item_t it;
    if ($urandom_range(1, ph.flip_div) == 1) fault_level = ~fault_level;
    if ($urandom_range(0, 7) == 0) on_level = ~on_level;
    it.link_operational = ($urandom_range(0, 15) != 0);
    it.status_word = 16'($urandom);
    it.status_word[SwFault] = fault_level;
    it.cmd_switch_on = on_level;
    {it.cmd_halt, it.cmd_fault_reset, it.cmd_enable_operation,
     it.cmd_quick_stop, it.cmd_enable_voltage} = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 99) < ph.noise_pct) begin
      it.status_word[SwFault] = 1'($urandom_range(0, 1));
      it.cmd_switch_on = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("ERROR at %0t: %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    err_count++;
  endtask

  // Put one period on the input and hold it until the transaction completes.
  task automatic send_period(input item_t it, input bit typed, input result_t tres);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tdata = {2'b00, it.cmd_halt, it.cmd_fault_reset, it.cmd_enable_operation,
                    it.cmd_quick_stop, it.cmd_enable_voltage, it.cmd_switch_on,
                    it.status_word};
    s_axis_tuser = it.link_operational;
    row_typed = typed;
    row_res = tres;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Register write; the caller lowers the valid after its last write.
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_index_i = idx;
    cfg_data_i = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Wait until every expected result is out and the pipeline has emptied.
  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Output side: random stall bursts, none in the calm part of the run.
  initial begin : out_ready_gen
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        m_axis_tready = 1'b1;
      end else if (hold > 0) begin
        hold--;
        m_axis_tready = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 4);
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Monitor: predicts on each input transaction, checks each output one.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    item_t   taken;
    result_t want;
    result_t got;
    bit      moved;
    if (!rst_ni) begin
      drive_model = '0;
      model_cfg.reset_period_cycles = DefaultPeriodCycles;
      model_cfg.reset_retry_limit = DefaultRetryLimit;
      stall_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (cfg_index_i)
          CfgIdxPeriod: model_cfg.reset_period_cycles = cfg_data_i;
          CfgIdxRetry:  model_cfg.reset_retry_limit = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        taken.link_operational     = s_axis_tuser;
        taken.status_word          = s_axis_tdata[15:0];
        taken.cmd_switch_on        = s_axis_tdata[16];
        taken.cmd_enable_voltage   = s_axis_tdata[17];
        taken.cmd_quick_stop       = s_axis_tdata[18];
        taken.cmd_enable_operation = s_axis_tdata[19];
        taken.cmd_fault_reset      = s_axis_tdata[20];
        taken.cmd_halt             = s_axis_tdata[21];
        want = predict_period(taken);
        pending_results.push_back(row_typed ? row_res : want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got.control_word = m_axis_tdata[8:0];
        got.fault_out    = m_axis_tdata[9];
        got.status_flags = m_axis_tdata[20:10];
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", 0, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          if (got.control_word !== want.control_word)
            report_mismatch("control_word", want.control_word, got.control_word);
          if (got.fault_out !== want.fault_out)
            report_mismatch("fault_out", want.fault_out, got.fault_out);
          if (got.status_flags !== want.status_flags)
            report_mismatch("status_flags", want.status_flags, got.status_flags);
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog: too long without any transaction ends the run.
  initial begin : watchdog
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence: reset, directed table, then the random phases.
  initial begin : stimulus
    int p;
    // Expected values typed in: state right after reset, link down, and the
    // period where a switch-on edge loads the sequence during a fault.
    dir_rows.push_back('{'{1'b1, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
                         1'b1, '{9'h000, 1'b0, 11'h010}});
    dir_rows.push_back('{'{1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
                         1'b1, '{9'h004, 1'b1, 11'h000}});
    dir_rows.push_back('{'{1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
                         1'b1, '{9'h182, 1'b1, 11'h7EF}});
    // Sequence running with the fault held, then link down in the middle.
    dir_rows.push_back('{'{1'b1, 16'h0008, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{'{1'b1, 16'h0008, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{'{1'b0, 16'h1234, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, '0});
    dir_rows.push_back('{'{1'b1, 16'h000A, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    // Fault clears and drops the remaining retries.
    dir_rows.push_back('{'{1'b1, 16'h0003, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{'{1'b1, 16'h0003, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '0});
    // Manual fault reset, then a fresh switch-on edge during a fault.
    dir_rows.push_back('{'{1'b1, 16'h0008, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{'{1'b1, 16'h0008, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{'{1'b1, 16'h000A, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{'{1'b1, 16'h0008, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, '0});
    dir_rows.push_back('{'{1'b1, 16'h0008, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0});
    // Switch-on edge while the link is down, with the fault still latched.
    dir_rows.push_back('{'{1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{'{1'b0, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{'{1'b1, 16'h0008, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0});
    // Everything but the fault bit, then enable operation without switched-on.
    dir_rows.push_back('{'{1'b1, 16'hFFF7, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{'{1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0});
    dir_rows.push_back('{'{1'b1, 16'h0020, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0});

    // Register settings per phase; phase 0 keeps the reset values. The large
    // period is followed by a small one so the counter starts above it.
    phases[0] = '{DefaultPeriodCycles, DefaultRetryLimit, 220, 128, 10, 1'b0};
    phases[1] = '{16'd1,     8'd1,   200, 32,   15, 1'b0};
    phases[2] = '{16'd0,     8'd5,   150, 16,   15, 1'b0};
    phases[3] = '{16'd4,     8'd0,   150, 16,   15, 1'b0};
    phases[4] = '{16'hFFFF,  8'hFF,  220, 1024, 0,  1'b0};
    phases[5] = '{16'd2,     8'd3,   200, 32,   10, 1'b0};
    for (p = 6; p < 9; p++) begin
      phases[p] = '{16'($urandom_range(1, 8)), 8'($urandom_range(1, 4)), 200, 32, 15, 1'b0};
    end
    phases[9] = '{16'd3,     8'hFF,  250, 24,   10, 1'b1};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_period(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

    for (p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        s_axis_tvalid = 1'b0;
        drain_results();
        if (p == 6) write_reg(CfgIdxUnused, 16'($urandom));
        write_reg(CfgIdxPeriod, phases[p].period);
        write_reg(CfgIdxRetry, {8'($urandom_range(0, 255)), phases[p].retry});
        cfg_valid_i = 1'b0;
      end
      calm = phases[p].calm;
      fault_level = 1'b1;
      repeat (phases[p].count) send_period(next_period_item(phases[p]), 1'b0, '0);
    end
    s_axis_tvalid = 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/scfa_pkg.sv
rtl/scfa_step.sv
rtl/servo_controlword_fault_autoreset_top.sv
tb/sv/servo_controlword_fault_autoreset_top_tb.sv
